// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the Life stencil block.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LGS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LGS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/lgs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Life generation stencil: sizes, register map, stage word, count helper.
// No dependencies.
package lgs_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int DIM_W   = 11;
	localparam int COORD_W = 10;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 11'd1000;
	localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 11'd1000;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_sel_t;

	// one accepted word after the row-store read stage
	typedef struct packed {
		logic               bot;
		logic               top_en;
		logic               mid_en;
		logic               first_col;
		logic               emit;
		logic               last;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} stage_t;

	function automatic logic [1:0] ones3(input logic [2:0] v);
		return 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
	endfunction

endpackage

// ===== rtl/core/life_generation_stencil.sv =====
`timescale 1ns / 1ps
// Life generation stencil (B3/S23) over a raster stream, top level.
// Depends on lgs_pkg and assert_macros.svh.
//
// While unstalled, one cell word is taken every clock; a word is held in the row-store read
// stage, then its result, if any, enters the output register; the pipeline is two registers
// deep and runs at one word per cycle, set by the single read and single write per
// cycle on the row store. The result for cell k leaves with word k+W+1, so append W+1 padding
// words to each frame of W*H cells; frame_last marks the last cell. Row stores are never
// cleared: rows outside the current frame are masked dead, so no clearing pass follows reset.
// Writing grid_width or grid_height restarts the frame and must only happen while idle.
`include "assert_macros.svh"

module life_generation_stencil #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lgs_pkg::ADDR_W-1:0] paddr,
	input  logic [lgs_pkg::DATA_W-1:0] pwdata,
	output logic [lgs_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       cell_valid,
	output logic                       cell_stall,
	input  logic                       cur_alive,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                        next_alive,
	output logic [lgs_pkg::COORD_W-1:0] out_col,
	output logic [lgs_pkg::COORD_W-1:0] out_row,
	output logic                        frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WD = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	logic [lgs_pkg::DIM_W-1:0] grid_width_q, grid_height_q;
	logic [WD-1:0]             w_eff;
	logic [RW-1:0]             h_eff;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          cfg_wr;
	logic          cell_acc;
	logic [WD-1:0] col_inc;
	logic          col_wrap;
	logic          first_col_c, last_c;
	logic [RW-1:0] er_full;
	logic [WD-1:0] ec_full;
	lgs_pkg::stage_t stage_c;

	logic            valid_s1;
	lgs_pkg::stage_t stage_s1;
	logic [CW-1:0]   idx_s1;
	logic [1:0]      rd_s1;
	logic            byp_s1;
	logic [1:0]      bypd_s1;

	logic [1:0] mem [MAX_WIDTH];
	logic       move_s1;
	logic       wr_en;
	logic [1:0] rd_eff;
	logic [1:0] wr_data;
	logic [2:0] newcol, e0, e1, e2;
	logic [3:0] n_live;
	logic       alive;

	logic [2:0] win_a_q, win_b_q;

	logic                        res_valid_q;
	logic                        next_alive_q, frame_last_q;
	logic [lgs_pkg::COORD_W-1:0] out_col_q, out_row_q;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (lgs_pkg::reg_sel_t'(paddr[2]))
			lgs_pkg::REG_GRID_WIDTH:  prdata = lgs_pkg::DATA_W'(grid_width_q);
			lgs_pkg::REG_GRID_HEIGHT: prdata = lgs_pkg::DATA_W'(grid_height_q);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lgs_pkg::GRID_WIDTH_RST;
			grid_height_q <= lgs_pkg::GRID_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (lgs_pkg::reg_sel_t'(paddr[2]))
				lgs_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[lgs_pkg::DIM_W-1:0];
				lgs_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[lgs_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to 1..MAX
	always_comb begin
		if (grid_width_q == '0)
			w_eff = WD'(1);
		else if (32'(grid_width_q) > 32'(MAX_WIDTH))
			w_eff = WD'(MAX_WIDTH);
		else
			w_eff = WD'(grid_width_q);
		if (grid_height_q == '0)
			h_eff = RW'(1);
		else if (32'(grid_height_q) > 32'(MAX_HEIGHT))
			h_eff = RW'(MAX_HEIGHT);
		else
			h_eff = RW'(grid_height_q);
	end

	// input side: position counters and masks
	assign move_s1    = valid_s1 && (!stage_s1.emit || !res_valid_q || !result_stall);
	assign cell_stall = valid_s1 && !move_s1;
	assign cell_acc   = cell_valid && !cell_stall;

	assign col_inc     = WD'(col_q) + WD'(1);
	assign col_wrap    = col_inc >= w_eff;
	assign first_col_c = (col_q == '0);
	assign last_c      = (row_q == h_eff + RW'(1)) && first_col_c;
	assign er_full     = first_col_c ? row_q - RW'(2) : row_q - RW'(1);
	assign ec_full     = first_col_c ? w_eff - WD'(1) : WD'(col_q) - WD'(1);

	always_comb begin
		stage_c.bot       = cur_alive && (row_q < h_eff);
		stage_c.top_en    = (row_q >= RW'(2)) && ((row_q - RW'(2)) < h_eff);
		stage_c.mid_en    = (row_q >= RW'(1)) && ((row_q - RW'(1)) < h_eff);
		stage_c.first_col = first_col_c;
		stage_c.emit      = (row_q >= RW'(2)) || ((row_q == RW'(1)) && !first_col_c);
		stage_c.last      = last_c;
		stage_c.col       = lgs_pkg::COORD_W'(ec_full);
		stage_c.row       = lgs_pkg::COORD_W'(er_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cell_acc) begin
			if (last_c) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	// row store: bit0 two rows up, bit1 one row up
	assign wr_en   = move_s1;
	assign rd_eff  = byp_s1 ? bypd_s1 : rd_s1;
	assign wr_data = {stage_s1.bot, rd_eff[1]};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[idx_s1] <= wr_data;
		if (cell_acc)
			rd_s1 <= mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (cell_acc) begin
			stage_s1 <= stage_c;
			idx_s1   <= col_q;
			byp_s1   <= wr_en && (idx_s1 == col_q);
			bypd_s1  <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cell_acc)
			valid_s1 <= 1'b1;
		else if (move_s1)
			valid_s1 <= 1'b0;
	end

	// window and rule
	assign newcol = {stage_s1.bot, rd_eff[1] & stage_s1.mid_en, rd_eff[0] & stage_s1.top_en};
	assign e0     = win_a_q;
	assign e1     = win_b_q;
	assign e2     = stage_s1.first_col ? 3'b000 : newcol;
	assign n_live = 4'(lgs_pkg::ones3(e0)) + 4'(lgs_pkg::ones3(e2)) + 4'(e1[0]) + 4'(e1[2]);
	assign alive  = (n_live == 4'd3) || ((n_live == 4'd2) && e1[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_a_q <= '0;
			win_b_q <= '0;
		end else if (cfg_wr) begin
			win_a_q <= '0;
			win_b_q <= '0;
		end else if (move_s1) begin
			if (stage_s1.last) begin
				win_a_q <= '0;
				win_b_q <= '0;
			end else begin
				win_a_q <= stage_s1.first_col ? 3'b000 : win_b_q;
				win_b_q <= newcol;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (move_s1 && stage_s1.emit)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move_s1 && stage_s1.emit) begin
			next_alive_q <= alive;
			out_col_q    <= stage_s1.col;
			out_row_q    <= stage_s1.row;
			frame_last_q <= stage_s1.last;
		end
	end

	assign result_valid = res_valid_q;
	assign next_alive   = next_alive_q;
	assign out_col      = out_col_q;
	assign out_row      = out_row_q;
	assign frame_last   = frame_last_q;

	`LGS_ASSERT_IMPLY(a_stall_needs_s1, clk, arst_n, cell_stall, valid_s1)
	`LGS_ASSERT_IMPLY(a_row_bound, clk, arst_n, 1'b1, row_q <= h_eff + RW'(1))
	`LGS_ASSERT_IMPLY(a_last_pos, clk, arst_n, result_valid && frame_last,
		out_col == lgs_pkg::COORD_W'(w_eff - WD'(1)))
	`LGS_ASSERT_NEXT(a_frame_restart, clk, arst_n, cell_acc && last_c,
		row_q == '0 && col_q == '0)

endmodule
